FILE: hw/rtl/ddcr_pkg.sv
package ddcr_pkg;

	localparam int SpeedW = 8;
	localparam int AgeW   = 16;
	localparam int CfgW   = 16;
	localparam int CfgIdxW = 3;

	localparam logic [AgeW-1:0] AgeMax = '1;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] CFG_RAMP_INTERVAL = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS    = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RAMP_STEP     = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TURN_STEP     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_WEAPON_MAX    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_DRIVE_MAX     = 3'd5;

	// Register values after reset.
	localparam logic [AgeW-1:0]   RST_RAMP_INTERVAL = 16'd50;
	localparam logic [AgeW-1:0]   RST_HOLD_TICKS    = 16'd200;
	localparam logic [SpeedW-1:0] RST_RAMP_STEP     = 8'd5;
	localparam logic [SpeedW-1:0] RST_TURN_STEP     = 8'd30;
	localparam logic [SpeedW-1:0] RST_WEAPON_MAX    = 8'd180;
	localparam logic [SpeedW-1:0] RST_DRIVE_MAX     = 8'd255;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_SET_DRIVE  = 3'd1,
		OP_SET_WEAPON = 3'd2,
		OP_BACK       = 3'd3,
		OP_RIGHT      = 3'd4,
		OP_LEFT       = 3'd5,
		OP_STOP       = 3'd6,
		OP_RELEASE    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_RIGHT = 2'd1,
		TURN_LEFT  = 2'd2
	} turn_dir_t;

	typedef struct packed {
		op_t               operation;
		logic [SpeedW-1:0] value;
	} item_t;

	typedef struct packed {
		logic [SpeedW-1:0] left_speed;
		logic              left_forward;
		logic [SpeedW-1:0] right_speed;
		logic              right_forward;
		logic              motors_halted;
		logic [SpeedW-1:0] weapon_level;
		logic              dial_valid;
		logic [SpeedW-1:0] dial_value;
	} result_t;

	typedef struct packed {
		logic [AgeW-1:0]   ramp_interval_ticks;
		logic [AgeW-1:0]   momentary_hold_ticks;
		logic [SpeedW-1:0] ramp_step;
		logic [SpeedW-1:0] turn_step;
		logic [SpeedW-1:0] weapon_max;
		logic [SpeedW-1:0] drive_max;
	} cfg_t;

	typedef struct packed {
		logic [SpeedW-1:0] base_speed;
		logic [SpeedW-1:0] drive_level;
		logic [SpeedW-1:0] drive_target;
		logic [SpeedW-1:0] weapon_now;
		logic [SpeedW-1:0] weapon_target;
		logic [SpeedW-1:0] turn_amount;
		turn_dir_t         turn_dir;
		logic [SpeedW-1:0] backward_amount;
		logic              halted_flag;
		logic              momentary_flag;
		logic [AgeW-1:0]   press_age;
		logic [AgeW-1:0]   ramp_age;
		logic              weapon_last_flag;
	} state_t;

	// Moves a level one step toward its target without passing it.
	function automatic logic [SpeedW-1:0] move_toward(input logic [SpeedW-1:0] lvl,
			input logic [SpeedW-1:0] tgt, input logic [SpeedW-1:0] step);
		logic [SpeedW-1:0] res;
		if (lvl < tgt) begin
			res = ((tgt - lvl) <= step) ? tgt : lvl + step;
		end else begin
			res = ((lvl - tgt) <= step) ? tgt : lvl - step;
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/ddcr_core.sv
module ddcr_core
	import ddcr_pkg::*;
(
	input  state_t  st,
	input  cfg_t    cfg,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic [SpeedW-1:0] dial_value;
	logic              dial_valid;
	logic [SpeedW:0]   turn_sum;
	logic [SpeedW-1:0] reduced;
	logic [AgeW-1:0]   press_inc;
	logic [AgeW-1:0]   ramp_inc;

	always_comb begin
		nxt        = st;
		dial_valid = 1'b0;
		dial_value = '0;
		press_inc  = (st.press_age != AgeMax) ? st.press_age + 1'b1 : st.press_age;
		ramp_inc   = (st.ramp_age != AgeMax) ? st.ramp_age + 1'b1 : st.ramp_age;
		turn_sum   = {1'b0, st.turn_amount} + {1'b0, cfg.turn_step};

		unique case (item.operation)
			OP_TICK: begin
				nxt.press_age = press_inc;
				nxt.ramp_age  = ramp_inc;
				if (st.momentary_flag && (press_inc > cfg.momentary_hold_ticks)) begin
					nxt.turn_dir        = TURN_NONE;
					nxt.turn_amount     = '0;
					nxt.backward_amount = '0;
					nxt.momentary_flag  = 1'b0;
				end
				if (((st.drive_level != st.drive_target) ||
						(st.weapon_now != st.weapon_target)) &&
						(ramp_inc >= cfg.ramp_interval_ticks)) begin
					nxt.drive_level = move_toward(st.drive_level, st.drive_target,
						cfg.ramp_step);
					nxt.weapon_now  = move_toward(st.weapon_now, st.weapon_target,
						cfg.ramp_step);
					nxt.ramp_age    = '0;
					dial_valid      = 1'b1;
					dial_value      = st.weapon_last_flag ? nxt.weapon_now : nxt.drive_level;
				end
			end
			OP_SET_DRIVE: begin
				nxt.halted_flag      = 1'b0;
				nxt.base_speed       = (item.value < cfg.drive_max) ? item.value : cfg.drive_max;
				nxt.drive_target     = nxt.base_speed;
				nxt.weapon_last_flag = 1'b0;
				dial_valid           = 1'b1;
				dial_value           = nxt.base_speed;
			end
			OP_SET_WEAPON: begin
				nxt.weapon_target    = (item.value < cfg.weapon_max) ? item.value :
					cfg.weapon_max;
				nxt.weapon_last_flag = 1'b1;
				dial_valid           = 1'b1;
				dial_value           = nxt.weapon_target;
			end
			OP_BACK: begin
				nxt.halted_flag      = 1'b0;
				nxt.press_age        = '0;
				nxt.momentary_flag   = 1'b1;
				nxt.backward_amount  = st.base_speed;
				nxt.turn_dir         = TURN_NONE;
				nxt.turn_amount      = '0;
				nxt.weapon_last_flag = 1'b0;
				dial_valid           = 1'b1;
				dial_value           = st.base_speed;
			end
			OP_RIGHT, OP_LEFT: begin
				nxt.halted_flag      = 1'b0;
				nxt.press_age        = '0;
				nxt.momentary_flag   = 1'b1;
				nxt.turn_dir         = (item.operation == OP_RIGHT) ? TURN_RIGHT : TURN_LEFT;
				nxt.turn_amount      = (turn_sum < {1'b0, st.base_speed}) ?
					turn_sum[SpeedW-1:0] : st.base_speed;
				nxt.weapon_last_flag = 1'b0;
				dial_valid           = 1'b1;
				dial_value           = st.base_speed - nxt.turn_amount;
			end
			OP_STOP: begin
				nxt.halted_flag      = 1'b1;
				nxt.press_age        = '0;
				nxt.turn_dir         = TURN_NONE;
				nxt.turn_amount      = '0;
				nxt.backward_amount  = '0;
				nxt.momentary_flag   = 1'b0;
				nxt.weapon_last_flag = 1'b0;
				dial_valid           = 1'b1;
			end
			OP_RELEASE: begin
				nxt.halted_flag     = 1'b0;
				nxt.press_age       = '0;
				nxt.turn_dir        = TURN_NONE;
				nxt.turn_amount     = '0;
				nxt.backward_amount = '0;
				nxt.momentary_flag  = 1'b0;
			end
		endcase
	end

	// Wheel commands come from the updated state.
	always_comb begin
		reduced           = (nxt.base_speed > nxt.turn_amount) ?
			nxt.base_speed - nxt.turn_amount : '0;
		res.motors_halted = nxt.halted_flag;
		res.weapon_level  = nxt.weapon_now;
		res.dial_valid    = dial_valid;
		res.dial_value    = dial_value;
		if (nxt.halted_flag) begin
			res.left_speed    = '0;
			res.right_speed   = '0;
			res.left_forward  = 1'b0;
			res.right_forward = 1'b0;
		end else if (nxt.backward_amount != '0) begin
			res.left_speed    = nxt.backward_amount;
			res.right_speed   = nxt.backward_amount;
			res.left_forward  = 1'b0;
			res.right_forward = 1'b0;
		end else begin
			res.left_forward  = 1'b1;
			res.right_forward = 1'b1;
			res.left_speed    = nxt.base_speed;
			res.right_speed   = nxt.base_speed;
			unique case (nxt.turn_dir)
				TURN_RIGHT: res.right_speed = reduced;
				TURN_LEFT:  res.left_speed  = reduced;
				default:    ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/differential_drive_command_ramp_top.sv
// Output: a result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while in_stall is low; the single update pass
// of the command core feeds the output register directly.
// Reset: arst_n clears all drive, weapon and button state and loads the
// register defaults; no clearing pass is needed.
module differential_drive_command_ramp_top
	import ddcr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  item_t              in_data,

	output logic               out_valid,
	input  logic               out_stall,
	output result_t            out_data
);

	// Configuration registers, to be written only while the block is idle; the block does not enforce this.
	cfg_t cfg_q;

	// Architectural state of the command block.
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;

	// Output register. The input side is held back only while a finished
	// result is still waiting downstream, so a beat can enter every cycle
	// as long as the consumer keeps taking results.
	logic    out_valid_q;
	result_t out_data_q;
	logic    in_take;

	assign in_stall = out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_interval_ticks  <= RST_RAMP_INTERVAL;
			cfg_q.momentary_hold_ticks <= RST_HOLD_TICKS;
			cfg_q.ramp_step            <= RST_RAMP_STEP;
			cfg_q.turn_step            <= RST_TURN_STEP;
			cfg_q.weapon_max           <= RST_WEAPON_MAX;
			cfg_q.drive_max            <= RST_DRIVE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RAMP_INTERVAL: cfg_q.ramp_interval_ticks  <= cfg_data;
				CFG_HOLD_TICKS:    cfg_q.momentary_hold_ticks <= cfg_data;
				CFG_RAMP_STEP:     cfg_q.ramp_step  <= cfg_data[SpeedW-1:0];
				CFG_TURN_STEP:     cfg_q.turn_step  <= cfg_data[SpeedW-1:0];
				CFG_WEAPON_MAX:    cfg_q.weapon_max <= cfg_data[SpeedW-1:0];
				CFG_DRIVE_MAX:     cfg_q.drive_max  <= cfg_data[SpeedW-1:0];
				default:           ;
			endcase
		end
	end

	// The core works out the next state and the result of one beat.
	ddcr_core u_core (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (in_data),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_take) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			out_data_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
